### hdl/hrbc_pkg.sv
// ----------------------------------------------------------------------------
// hrbc_pkg
// Shared types and constants for the hex record byte counter.
// ----------------------------------------------------------------------------
package hrbc_pkg;

   // Widths of the result fields
   localparam int OUT_COUNT_WIDTH = 32;
   localparam int ADDR_WIDTH      = 16;
   localparam int STATUS_WIDTH    = 2;

   // Character constants
   localparam logic [7:0] CHAR_MASK  = 8'h7F;  // 0177
   localparam logic [6:0] CHAR_END   = 7'h00;
   localparam logic [6:0] CHAR_COLON = 7'h3A;  // ':'
   localparam logic [6:0] DIGIT_ZERO = 7'h30;  // 060
   localparam logic [6:0] LETTER_A   = 7'h41;

   // Status codes
   localparam logic [STATUS_WIDTH-1:0] ST_RUN  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_DONE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_BAD  = 2'd2;

   typedef enum logic [11:0] {
      PH_WAIT    = 12'h001,
      PH_LEN_HI  = 12'h002,
      PH_LEN_LO  = 12'h004,
      PH_ADDR0   = 12'h008,
      PH_ADDR1   = 12'h010,
      PH_ADDR2   = 12'h020,
      PH_ADDR3   = 12'h040,
      PH_TYPE_HI = 12'h080,
      PH_TYPE_LO = 12'h100,
      PH_DATA_HI = 12'h200,
      PH_DATA_LO = 12'h400,
      PH_STOP    = 12'h800
   } phase_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic [OUT_COUNT_WIDTH-1:0] data_bytes;
      logic [OUT_COUNT_WIDTH-1:0] records_seen;
      logic [ADDR_WIDTH-1:0]      load_address;
      logic [STATUS_WIDTH-1:0]    status;
   } result_type;

   // Upper-case hex digit decode
   function automatic hex_type hex_decode(input logic [6:0] c);
      hex_type h;
      h.ok    = 1'b0;
      h.value = 4'd0;
      if (c inside {[DIGIT_ZERO : DIGIT_ZERO + 7'd9]}) begin
         h.ok    = 1'b1;
         h.value = 4'(c - DIGIT_ZERO);
      end else if (c inside {[LETTER_A : LETTER_A + 7'd5]}) begin
         h.ok    = 1'b1;
         h.value = 4'(c - LETTER_A + 7'd10);
      end
      return h;
   endfunction

endpackage

### hdl/hrbc_if.sv
// ----------------------------------------------------------------------------
// hrbc_if
// Valid/ready channels: character items in, count snapshots out.
// ----------------------------------------------------------------------------
interface hrbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

interface hrbc_rsp_if;
   import hrbc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OUT_COUNT_WIDTH-1:0] data_bytes;
   logic [OUT_COUNT_WIDTH-1:0] records_seen;
   logic [ADDR_WIDTH-1:0]      load_address;
   logic [STATUS_WIDTH-1:0]    status;

   modport source (output valid, output data_bytes, output records_seen,
                   output load_address, output status, input ready);
   modport sink   (input valid, input data_bytes, input records_seen,
                   input load_address, input status, output ready);
endinterface

### hdl/hrbc_in_stage.sv
// ----------------------------------------------------------------------------
// hrbc_in_stage
// Input register: holds one character item until the scanner takes it.
// ----------------------------------------------------------------------------
module hrbc_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] in_character,
   output logic       in_ready,
   input  logic       take,
   output logic       step,
   output logic [7:0] character
);
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] character_ff;

   assign in_ready  = !valid_ff || take;
   assign step      = valid_ff && take;
   assign character = character_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         character_ff <= in_character;
      end
   end

endmodule

### hdl/hrbc_scan.sv
// ----------------------------------------------------------------------------
// hrbc_scan
// Record scanner: phase sequencer, counters and load address.
// ----------------------------------------------------------------------------
module hrbc_scan #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          character,
   output hrbc_pkg::result_type result
);
   import hrbc_pkg::*;

   phase_type                   phase_ff,       phase_in;
   logic [3:0]                  high_nibble_ff, high_nibble_in;
   logic [7:0]                  remaining_ff,   remaining_in;
   logic [ADDR_WIDTH-1:0]       address_ff,     address_in;
   logic [COUNT_WIDTH-1:0]      bytes_ff,       bytes_in;
   logic [COUNT_WIDTH-1:0]      records_ff,     records_in;
   logic [STATUS_WIDTH-1:0]     status_ff,      status_in;

   logic [7:0]                  masked;
   logic [6:0]                  c7;
   hex_type                     hex;
   logic [COUNT_WIDTH-1:0]      bytes_inc;
   logic [COUNT_WIDTH-1:0]      records_inc;

   assign masked = character & CHAR_MASK;
   assign c7     = masked[6:0];
   assign hex    = hex_decode(c7);

   // saturating increments
   assign bytes_inc   = (bytes_ff == {COUNT_WIDTH{1'b1}}) ? bytes_ff
                                                          : bytes_ff + 1'b1;
   assign records_inc = (records_ff == {COUNT_WIDTH{1'b1}}) ? records_ff
                                                            : records_ff + 1'b1;

   always_comb begin
      phase_in       = phase_ff;
      high_nibble_in = high_nibble_ff;
      remaining_in   = remaining_ff;
      address_in     = address_ff;
      bytes_in       = bytes_ff;
      records_in     = records_ff;
      status_in      = status_ff;
      if (step) begin
         case (phase_ff)
            PH_STOP: begin
            end
            PH_WAIT: begin
               if (c7 == CHAR_END) begin
                  status_in = (records_ff != '0) ? ST_DONE : ST_BAD;
                  phase_in  = PH_STOP;
               end else if (c7 == CHAR_COLON) begin
                  records_in = records_inc;
                  phase_in   = PH_LEN_HI;
               end
            end
            PH_LEN_HI, PH_LEN_LO, PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3,
            PH_TYPE_HI, PH_TYPE_LO, PH_DATA_HI, PH_DATA_LO: begin
               if (!hex.ok) begin
                  status_in = ST_BAD;
                  phase_in  = PH_STOP;
               end else begin
                  case (phase_ff)
                     PH_LEN_HI: begin
                        high_nibble_in = hex.value;
                        phase_in       = PH_LEN_LO;
                     end
                     PH_LEN_LO: begin
                        remaining_in = {high_nibble_ff, hex.value};
                        phase_in     = PH_ADDR0;
                     end
                     PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3: begin
                        address_in = {address_ff[ADDR_WIDTH-5:0], hex.value};
                        phase_in   = phase_type'({phase_ff[10:0], 1'b0});
                     end
                     PH_TYPE_HI: begin
                        high_nibble_in = hex.value;
                        phase_in       = PH_TYPE_LO;
                     end
                     PH_TYPE_LO: begin
                        phase_in = (remaining_ff != 8'd0) ? PH_DATA_HI : PH_WAIT;
                     end
                     PH_DATA_HI: begin
                        high_nibble_in = hex.value;
                        phase_in       = PH_DATA_LO;
                     end
                     PH_DATA_LO: begin
                        bytes_in     = bytes_inc;
                        address_in   = address_ff + 1'b1;
                        remaining_in = remaining_ff - 1'b1;
                        phase_in     = (remaining_ff != 8'd1) ? PH_DATA_HI : PH_WAIT;
                     end
                     default: begin
                        status_in = ST_BAD;
                        phase_in  = PH_STOP;
                     end
                  endcase
               end
            end
            default: begin
               status_in = ST_BAD;
               phase_in  = PH_STOP;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_WAIT;
         high_nibble_ff <= 4'd0;
         remaining_ff   <= 8'd0;
         address_ff     <= '0;
         bytes_ff       <= '0;
         records_ff     <= '0;
         status_ff      <= ST_RUN;
      end else begin
         phase_ff       <= phase_in;
         high_nibble_ff <= high_nibble_in;
         remaining_ff   <= remaining_in;
         address_ff     <= address_in;
         bytes_ff       <= bytes_in;
         records_ff     <= records_in;
         status_ff      <= status_in;
      end
   end

   // counts shown in their low 32 bits, zero-extended when narrower
   generate
      if (COUNT_WIDTH >= OUT_COUNT_WIDTH) begin : g_wide
         assign result.data_bytes   = bytes_in[OUT_COUNT_WIDTH-1:0];
         assign result.records_seen = records_in[OUT_COUNT_WIDTH-1:0];
      end else begin : g_narrow
         assign result.data_bytes   = {{(OUT_COUNT_WIDTH-COUNT_WIDTH){1'b0}}, bytes_in};
         assign result.records_seen = {{(OUT_COUNT_WIDTH-COUNT_WIDTH){1'b0}}, records_in};
      end
   endgenerate

   assign result.load_address = address_in;
   assign result.status       = status_in;

endmodule

### hdl/hrbc_out_stage.sv
// ----------------------------------------------------------------------------
// hrbc_out_stage
// Result register: holds one snapshot until the sink takes it.
// ----------------------------------------------------------------------------
module hrbc_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  hrbc_pkg::result_type result_in,
   output logic                 take,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hrbc_pkg::result_type result_out
);
   import hrbc_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign take       = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign result_out = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

endmodule

### hdl/hex_record_byte_counter.sv
// ----------------------------------------------------------------------------
// hex_record_byte_counter
// Scans an Intel-hex style character stream, counting records and data bytes.
// ----------------------------------------------------------------------------
// Takes one character per item (low 7 bits used, zero means end of input) and
// returns one result item per character: data byte count, record count, the
// running load address and a status (running, done, bad). Throughput is one
// item per clock. An accepted item sits in the input register, the scanner's
// combinational update feeds the result register, and the result is shown
// from there. Both registers accept a new item while the one ahead is taken,
// so only back-pressure on the result channel slows the block. No clearing
// pass is needed after reset. Once the status leaves running the block holds
// its outputs and ignores further input.
module hex_record_byte_counter #(
   parameter int COUNT_WIDTH = 32      // internal counter width, 8 to 64
) (
   input logic         clock,
   input logic         reset,
   hrbc_req_if.sink    req_if,
   hrbc_rsp_if.source  rsp_if
);
   import hrbc_pkg::*;

   logic       take;       // result register can load this cycle
   logic       step;       // held item moves into the scanner
   logic [7:0] character;  // held character
   result_type next_result;
   result_type shown;

   // input register
   hrbc_in_stage u_in (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_if.valid),
      .in_character (req_if.character),
      .in_ready     (req_if.ready),
      .take         (take),
      .step         (step),
      .character    (character)
   );

   // state update; result is the post-update snapshot
   hrbc_scan #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .character (character),
      .result    (next_result)
   );

   // result register
   hrbc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .result_in  (next_result),
      .take       (take),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .result_out (shown)
   );

   assign rsp_if.data_bytes   = shown.data_bytes;
   assign rsp_if.records_seen = shown.records_seen;
   assign rsp_if.load_address = shown.load_address;
   assign rsp_if.status       = shown.status;

endmodule

### hdl/hrbc_checker.sv
// ----------------------------------------------------------------------------
// hrbc_checker
// Port-level checks on the result stream of the byte counter.
// ----------------------------------------------------------------------------
module hrbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_data_bytes,
   input logic [31:0] rsp_records_seen,
   input logic [15:0] rsp_load_address,
   input logic [1:0]  rsp_status
);
   import hrbc_pkg::*;

   logic        rsp_take;
   logic        seen_ff;
   logic [31:0] last_bytes_ff;
   logic [31:0] last_records_ff;
   logic [15:0] last_address_ff;
   logic [1:0]  last_status_ff;
   logic [32:0] bytes_step;
   logic [32:0] records_step;

   assign rsp_take     = rsp_valid && rsp_ready;
   assign bytes_step   = {1'b0, rsp_data_bytes} - {1'b0, last_bytes_ff};
   assign records_step = {1'b0, rsp_records_seen} - {1'b0, last_records_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_take) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         last_bytes_ff   <= rsp_data_bytes;
         last_records_ff <= rsp_records_seen;
         last_address_ff <= rsp_load_address;
         last_status_ff  <= rsp_status;
      end
   end

   // stalled result holds its counts and status
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_bytes)
         && $stable(rsp_records_seen) && $stable(rsp_status))
      else $error("result changed while stalled");

   // nothing offered straight out of reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // once stopped, every later item repeats the final snapshot
   a_frozen: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff && last_status_ff != ST_RUN |->
         rsp_status == last_status_ff && rsp_data_bytes == last_bytes_ff
         && rsp_records_seen == last_records_ff
         && rsp_load_address == last_address_ff)
      else $error("outputs moved after stop");

   // one character adds at most one record and one data byte, never both
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff |-> records_step <= 33'd1 && bytes_step <= 33'd1
         && !(records_step == 33'd1 && bytes_step == 33'd1))
      else $error("count stepped wrongly");

endmodule

bind hex_record_byte_counter hrbc_checker u_hrbc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_data_bytes   (rsp_if.data_bytes),
   .rsp_records_seen (rsp_if.records_seen),
   .rsp_load_address (rsp_if.load_address),
   .rsp_status       (rsp_if.status)
);
